// ===== rtl/bbc_pkg.sv =====
// shared types and constants for the bracket balance checker
package bbc_pkg;

	localparam int STACK_DEPTH_DEF = 64;
	localparam int FIFO_DEPTH      = 4;
	localparam int LIMIT_W         = 7;

	localparam logic [7:0] CH_ROUND_OPEN   = 8'h28;
	localparam logic [7:0] CH_ROUND_CLOSE  = 8'h29;
	localparam logic [7:0] CH_SQUARE_OPEN  = 8'h5b;
	localparam logic [7:0] CH_SQUARE_CLOSE = 8'h5d;
	localparam logic [7:0] CH_CURLY_OPEN   = 8'h7b;
	localparam logic [7:0] CH_CURLY_CLOSE  = 8'h7d;

	typedef enum logic [1:0] {
		CLS_OTHER = 2'd0,
		CLS_OPEN  = 2'd1,
		CLS_CLOSE = 2'd2
	} sym_class_t;

	typedef enum logic [1:0] {
		KIND_ROUND  = 2'd0,
		KIND_SQUARE = 2'd1,
		KIND_CURLY  = 2'd2
	} kind_t;

	typedef enum logic [2:0] {
		ERR_NONE     = 3'd0,
		ERR_EMPTY    = 3'd1,
		ERR_WRONG    = 3'd2,
		ERR_OVERFLOW = 3'd3,
		ERR_OPEN     = 3'd4
	} err_t;

	typedef struct packed {
		sym_class_t cls;
		kind_t      kind;
		logic       last;
	} op_t;

endpackage

// ===== rtl/bbc_front.sv =====
// front end: takes characters and classifies them into stack operations
module bbc_front (
	input  logic             s_axis_tvalid,
	output logic             s_axis_tready,
	input  logic [7:0]       s_axis_tdata,   // symbol
	input  logic             s_axis_tlast,
	output logic             push_valid,
	input  logic             push_ready,
	output bbc_pkg::op_t     push_op
);
	import bbc_pkg::*;

	always_comb begin
		push_op.last = s_axis_tlast;
		push_op.cls  = CLS_OTHER;
		push_op.kind = KIND_ROUND;
		case (s_axis_tdata)
			CH_ROUND_OPEN: begin
				push_op.cls  = CLS_OPEN;
				push_op.kind = KIND_ROUND;
			end
			CH_SQUARE_OPEN: begin
				push_op.cls  = CLS_OPEN;
				push_op.kind = KIND_SQUARE;
			end
			CH_CURLY_OPEN: begin
				push_op.cls  = CLS_OPEN;
				push_op.kind = KIND_CURLY;
			end
			CH_ROUND_CLOSE: begin
				push_op.cls  = CLS_CLOSE;
				push_op.kind = KIND_ROUND;
			end
			CH_SQUARE_CLOSE: begin
				push_op.cls  = CLS_CLOSE;
				push_op.kind = KIND_SQUARE;
			end
			CH_CURLY_CLOSE: begin
				push_op.cls  = CLS_CLOSE;
				push_op.kind = KIND_CURLY;
			end
			default: begin
				push_op.cls  = CLS_OTHER;
				push_op.kind = KIND_ROUND;
			end
		endcase
	end

	assign push_valid    = s_axis_tvalid;
	assign s_axis_tready = push_ready;

endmodule

// ===== rtl/bbc_fifo.sv =====
// short operation queue between front end and stack engine
module bbc_fifo (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             wr_valid,
	output logic             wr_ready,
	input  bbc_pkg::op_t     wr_op,
	output logic             rd_valid,
	input  logic             rd_ready,
	output bbc_pkg::op_t     rd_op
);
	import bbc_pkg::*;

	localparam int PW = $clog2(FIFO_DEPTH);
	localparam int CW = $clog2(FIFO_DEPTH + 1);

	op_t           entry_q [FIFO_DEPTH];
	logic [PW-1:0] wr_ptr_q;
	logic [PW-1:0] rd_ptr_q;
	logic [CW-1:0] count_q;
	logic          do_wr;
	logic          do_rd;

	assign wr_ready = (count_q != CW'(FIFO_DEPTH));
	assign rd_valid = (count_q != '0);
	assign rd_op    = entry_q[rd_ptr_q];
	assign do_wr    = wr_valid && wr_ready;
	assign do_rd    = rd_valid && rd_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_wr) begin
				wr_ptr_q <= (wr_ptr_q == PW'(FIFO_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_rd) begin
				rd_ptr_q <= (rd_ptr_q == PW'(FIFO_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (do_wr && !do_rd) begin
				count_q <= count_q + 1'b1;
			end else if (do_rd && !do_wr) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (do_wr) begin
			entry_q[wr_ptr_q] <= wr_op;
		end
	end

endmodule

// ===== rtl/bbc_back.sv =====
// stack engine: carries out push and pop, latches faults, forms the result
module bbc_back #(
	parameter int STACK_DEPTH = bbc_pkg::STACK_DEPTH_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic [bbc_pkg::LIMIT_W-1:0]   stack_limit,
	input  logic                          op_valid,
	output logic                          op_ready,
	input  bbc_pkg::op_t                  op,
	output logic                          res_valid,
	input  logic                          res_ready,
	output logic                          res_balanced,
	output logic [2:0]                    res_reason
);
	import bbc_pkg::*;

	localparam int AW = $clog2(STACK_DEPTH);
	localparam int DW = $clog2(STACK_DEPTH + 1);
	localparam int LW = (DW > LIMIT_W) ? DW : LIMIT_W;

	kind_t         mem [STACK_DEPTH];
	kind_t         rd_q;
	kind_t         top_q;
	logic [DW-1:0] depth_q;
	err_t          err_q;
	logic          out_valid_q;
	logic          out_balanced_q;
	err_t          out_reason_q;

	logic [LW-1:0] limit_eff;
	logic          take;
	logic [DW-1:0] depth_nxt;
	err_t          err_nxt;
	kind_t         top_nxt;
	logic          mem_we;
	err_t          reason;
	logic [DW-1:0] rd_addr;

	always_comb begin
		if (stack_limit == '0) begin
			limit_eff = LW'(1);
		end else if (LW'(stack_limit) > LW'(STACK_DEPTH)) begin
			limit_eff = LW'(STACK_DEPTH);
		end else begin
			limit_eff = LW'(stack_limit);
		end
	end

	// a final character may only go once the result slot is free
	assign op_ready = !(op.last && out_valid_q && !res_ready);
	assign take     = op_valid && op_ready;

	always_comb begin
		depth_nxt = depth_q;
		err_nxt   = err_q;
		top_nxt   = top_q;
		mem_we    = 1'b0;
		reason    = ERR_NONE;
		if (take && err_q == ERR_NONE) begin
			case (op.cls)
				CLS_OPEN: begin
					if (LW'(depth_q) >= limit_eff) begin
						err_nxt = ERR_OVERFLOW;
					end else begin
						mem_we    = 1'b1;
						top_nxt   = op.kind;
						depth_nxt = depth_q + 1'b1;
					end
				end
				CLS_CLOSE: begin
					if (depth_q == '0) begin
						err_nxt = ERR_EMPTY;
					end else if (top_q != op.kind) begin
						err_nxt = ERR_WRONG;
					end else begin
						// entry below the top is already waiting in rd_q
						top_nxt   = rd_q;
						depth_nxt = depth_q - 1'b1;
					end
				end
				default: begin
				end
			endcase
		end
		if (err_nxt != ERR_NONE) begin
			reason = err_nxt;
		end else if (depth_nxt != '0) begin
			reason = ERR_OPEN;
		end
		if (take && op.last) begin
			depth_nxt = '0;
			err_nxt   = ERR_NONE;
		end
	end

	// prefetch the entry that sits just below the next top
	assign rd_addr = depth_nxt - DW'(2);

	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem[depth_q[AW-1:0]] <= op.kind;
		end
		rd_q  <= mem[rd_addr[AW-1:0]];
		top_q <= top_nxt;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			depth_q     <= '0;
			err_q       <= ERR_NONE;
			out_valid_q <= 1'b0;
		end else begin
			depth_q <= depth_nxt;
			err_q   <= err_nxt;
			if (take && op.last) begin
				out_valid_q <= 1'b1;
			end else if (res_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (take && op.last) begin
			out_balanced_q <= (reason == ERR_NONE);
			out_reason_q   <= reason;
		end
	end

	assign res_valid    = out_valid_q;
	assign res_balanced = out_balanced_q;
	assign res_reason   = out_reason_q;

endmodule

// ===== rtl/bracket_balance_checker.sv =====
// top level: bracket balance checker over a character stream
// one character accepted per cycle while the queue has room; the stack engine retires one per
// cycle unless a last character waits on a full result slot; m_axis valid is registered
// top of stack lives in a register and the entry below it is read ahead from the stack memory
// reset clears depth, error, queue and output valid; stack_limit returns to 64
// the stack memory needs no clearing pass, entries are only used after a push
module bracket_balance_checker #(
	parameter int STACK_DEPTH = bbc_pkg::STACK_DEPTH_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [7:0]  s_axis_tdata,   // [7:0] symbol
	input  logic        s_axis_tlast,   // last
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [7:0]  m_axis_tdata,   // [0] balanced, [3:1] fail_reason, [7:4] zero
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [6:0]  cfg_data        // stack_limit
);
	import bbc_pkg::*;

	logic [LIMIT_W-1:0] stack_limit_q;
	logic               f_valid;
	logic               f_ready;
	op_t                f_op;
	logic               b_valid;
	logic               b_ready;
	op_t                b_op;
	logic               res_balanced;
	logic [2:0]         res_reason;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			stack_limit_q <= LIMIT_W'(64);
		end else if (cfg_valid) begin
			stack_limit_q <= cfg_data;
		end
	end

	bbc_front u_front (
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tlast  (s_axis_tlast),
		.push_valid    (f_valid),
		.push_ready    (f_ready),
		.push_op       (f_op)
	);

	bbc_fifo u_fifo (
		.clk      (clk),
		.arst_n   (arst_n),
		.wr_valid (f_valid),
		.wr_ready (f_ready),
		.wr_op    (f_op),
		.rd_valid (b_valid),
		.rd_ready (b_ready),
		.rd_op    (b_op)
	);

	bbc_back #(
		.STACK_DEPTH (STACK_DEPTH)
	) u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.stack_limit  (stack_limit_q),
		.op_valid     (b_valid),
		.op_ready     (b_ready),
		.op           (b_op),
		.res_valid    (m_axis_tvalid),
		.res_ready    (m_axis_tready),
		.res_balanced (res_balanced),
		.res_reason   (res_reason)
	);

	assign m_axis_tdata = {4'b0000, res_reason, res_balanced};

endmodule

// ===== tb/sv/bracket_balance_checker_tb.sv =====
`timescale 1ns / 100ps
// testbench for the bracket balance checker: stream stimulus, bracket-stack predictor and checker
module bracket_balance_checker_tb;
	import bbc_pkg::*;

	localparam int STACK_N       = STACK_DEPTH_DEF;
	localparam int IDLE_LIMIT    = 2000;
	localparam int SETTLE_CYCLES = 4;

	typedef struct packed {
		logic balanced;
		err_t reason;
	} verdict_t;

	logic       clk           = 1'b0;
	logic       arst_n        = 1'b0;
	logic       s_axis_tvalid = 1'b0;
	logic       s_axis_tready;
	logic [7:0] s_axis_tdata  = 8'h00;   // [7:0] symbol
	logic       s_axis_tlast  = 1'b0;    // last
	logic       m_axis_tvalid;
	logic       m_axis_tready = 1'b0;
	logic [7:0] m_axis_tdata;            // [0] balanced, [3:1] fail_reason, [7:4] zero
	logic       cfg_valid     = 1'b0;
	logic       cfg_ready;
	logic [6:0] cfg_data      = 7'd0;    // stack_limit

	// predictor state
	kind_t      open_kinds_mdl [STACK_N];
	int         depth_mdl  = 0;
	err_t       fault_mdl  = ERR_NONE;
	logic [6:0] limit_reg  = 7'd64;
	verdict_t   pending_verdicts [$];

	logic [7:0] text_buf [$];
	bit         steady        = 1'b0;
	int         symbols_sent  = 0;
	int         mismatches    = 0;
	int         idle_cycles   = 0;
	int         reason_tally [5] = '{default: 0};

	bracket_balance_checker i_dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tlast  (s_axis_tlast),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.cfg_valid     (cfg_valid),
		.cfg_ready     (cfg_ready),
		.cfg_data      (cfg_data)
	);

	always #2 clk = ~clk;

	function automatic int effective_limit();
		int lim;
		lim = (limit_reg == 7'd0) ? 1 : int'(limit_reg);
		if (lim > STACK_N)
			lim = STACK_N;
		return lim;
	endfunction

	// updates the stack model for one accepted character, queues a verdict on the last one
	function automatic void track_symbol(input logic [7:0] sym, input logic last);
		bit       is_open;
		bit       is_close;
		kind_t    k;
		verdict_t v;
		is_open  = 1'b0;
		is_close = 1'b0;
		k        = KIND_ROUND;
		case (sym)
			CH_ROUND_OPEN: begin
				is_open = 1'b1;
				k       = KIND_ROUND;
			end
			CH_SQUARE_OPEN: begin
				is_open = 1'b1;
				k       = KIND_SQUARE;
			end
			CH_CURLY_OPEN: begin
				is_open = 1'b1;
				k       = KIND_CURLY;
			end
			CH_ROUND_CLOSE: begin
				is_close = 1'b1;
				k        = KIND_ROUND;
			end
			CH_SQUARE_CLOSE: begin
				is_close = 1'b1;
				k        = KIND_SQUARE;
			end
			CH_CURLY_CLOSE: begin
				is_close = 1'b1;
				k        = KIND_CURLY;
			end
			default: ;
		endcase
		if (fault_mdl == ERR_NONE) begin
			if (is_open) begin
				if (depth_mdl >= effective_limit()) begin
					fault_mdl = ERR_OVERFLOW;
				end else begin
					open_kinds_mdl[depth_mdl] = k;
					depth_mdl++;
				end
			end else if (is_close) begin
				if (depth_mdl == 0)
					fault_mdl = ERR_EMPTY;
				else if (open_kinds_mdl[depth_mdl - 1] != k)
					fault_mdl = ERR_WRONG;
				else
					depth_mdl--;
			end
		end
		if (last) begin
			if (fault_mdl != ERR_NONE)
				v.reason = fault_mdl;
			else if (depth_mdl != 0)
				v.reason = ERR_OPEN;
			else
				v.reason = ERR_NONE;
			v.balanced = (v.reason == ERR_NONE);
			pending_verdicts.push_back(v);
			reason_tally[v.reason]++;
			depth_mdl = 0;
			fault_mdl = ERR_NONE;
		end
	endfunction

	function automatic logic [7:0] open_char(input kind_t k);
		case (k)
			KIND_SQUARE: return CH_SQUARE_OPEN;
			KIND_CURLY:  return CH_CURLY_OPEN;
			default:     return CH_ROUND_OPEN;
		endcase
	endfunction

	function automatic logic [7:0] close_char(input kind_t k);
		case (k)
			KIND_SQUARE: return CH_SQUARE_CLOSE;
			KIND_CURLY:  return CH_CURLY_CLOSE;
			default:     return CH_ROUND_CLOSE;
		endcase
	endfunction

	function automatic logic [7:0] any_bracket();
		kind_t k;
		k = kind_t'($urandom_range(0, 2));
		return $urandom_range(0, 1) ? open_char(k) : close_char(k);
	endfunction

	function automatic logic [7:0] plain_byte();
		logic [7:0] b;
		do
			b = 8'($urandom_range(0, 255));
		while (b inside {CH_ROUND_OPEN, CH_ROUND_CLOSE, CH_SQUARE_OPEN, CH_SQUARE_CLOSE,
			CH_CURLY_OPEN, CH_CURLY_CLOSE});
		return b;
	endfunction

	// properly nested text; climb opens brackets toward max_d first, with plain bytes but no closers in between
	function automatic void build_nested(input int max_d, input int steps, input bit climb);
		kind_t open_stack [$];
		kind_t k;
		int    r;
		text_buf.delete();
		for (int i = 0; i < steps; i++) begin
			r = $urandom_range(0, 99);
			if (open_stack.size() >= max_d)
				climb = 1'b0;
			if (open_stack.size() < max_d && r < (climb ? 85 : 40)) begin
				k = kind_t'($urandom_range(0, 2));
				open_stack.push_back(k);
				text_buf.push_back(open_char(k));
			end else if (open_stack.size() != 0 && !climb && r < 75) begin
				text_buf.push_back(close_char(open_stack.pop_back()));
			end else begin
				text_buf.push_back(plain_byte());
			end
		end
		while (open_stack.size() != 0)
			text_buf.push_back(close_char(open_stack.pop_back()));
	endfunction

	// one local change: a byte set to a random bracket, an extra closer or a dropped character
	function automatic void corrupt_text();
		int idx;
		idx = $urandom_range(0, text_buf.size() - 1);
		case ($urandom_range(0, 2))
			0: text_buf[idx] = any_bracket();
			1: text_buf.insert(idx, close_char(kind_t'($urandom_range(0, 2))));
			default: if (text_buf.size() > 1) text_buf.delete(idx);
		endcase
	endfunction

	function automatic void build_noise();
		text_buf.delete();
		repeat ($urandom_range(1, 16))
			text_buf.push_back($urandom_range(0, 1) ? any_bracket() : 8'($urandom_range(0, 255)));
	endfunction

	task automatic send_symbol(input logic [7:0] sym, input logic last);
		while (!steady && $urandom_range(0, 99) < 13) begin
			s_axis_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata  <= sym;
		s_axis_tlast  <= last;
		do @(posedge clk); while (!s_axis_tready);
		track_symbol(sym, last);
		symbols_sent++;
	endtask

	task automatic send_text();
		foreach (text_buf[i])
			send_symbol(text_buf[i], i == text_buf.size() - 1);
	endtask

	task automatic send_str(input string s);
		for (int i = 0; i < s.len(); i++)
			send_symbol(s[i], i == s.len() - 1);
	endtask

	// stop sending and let every pending verdict come out before touching the register
	task automatic drain_verdicts();
		s_axis_tvalid <= 1'b0;
		while (pending_verdicts.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_limit(input logic [6:0] value);
		drain_verdicts();
		cfg_valid <= 1'b1;
		cfg_data  <= value;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
		limit_reg = value;
	endtask

	task automatic test_directed();
		send_str("()");
		send_str("([{}])");
		send_str("]");
		send_str("(]");
		send_str("{)");
		send_str("((");
		send_str("a");
		send_symbol(8'h00, 1'b1);
		send_symbol(8'hff, 1'b1);
		// fault latched, closers after it must not pop
		send_str("(}))");
		// opener on the final character still counts
		send_str("[");
	endtask

	task automatic test_limit_bounds();
		write_limit(7'd0);
		send_str("()");
		send_str("((");
		send_str("{}[]");
		write_limit(7'd1);
		send_str("[]{}");
		send_str("[[");
		write_limit(7'd127);
		text_buf.delete();
		repeat (STACK_N) text_buf.push_back(CH_ROUND_OPEN);
		repeat (STACK_N) text_buf.push_back(CH_ROUND_CLOSE);
		send_text();
		text_buf.delete();
		repeat (STACK_N + 1) text_buf.push_back(CH_CURLY_OPEN);
		text_buf.push_back(CH_CURLY_CLOSE);
		send_text();
		write_limit(7'd64);
		text_buf.delete();
		repeat (STACK_N + 1) text_buf.push_back(CH_SQUARE_OPEN);
		send_text();
	endtask

	task automatic test_limit_lowered();
		write_limit(7'd64);
		repeat (5) send_symbol(CH_ROUND_OPEN, 1'b0);
		write_limit(7'd2);
		send_symbol(CH_ROUND_CLOSE, 1'b0);
		send_symbol(CH_ROUND_OPEN, 1'b0);
		send_symbol("x", 1'b1);
		write_limit(7'd64);
		repeat (3) send_symbol(CH_SQUARE_OPEN, 1'b0);
		write_limit(7'd2);
		send_symbol(CH_SQUARE_CLOSE, 1'b0);
		send_symbol(CH_SQUARE_CLOSE, 1'b0);
		send_symbol(CH_ROUND_OPEN, 1'b0);
		send_symbol(CH_ROUND_CLOSE, 1'b0);
		send_symbol(CH_SQUARE_CLOSE, 1'b1);
	endtask

	// mostly well-nested strings, some with one local change, the rest raw noise
	task automatic test_random_phase(input logic [6:0] lim, input int quota, input bit no_idle);
		int stop_at;
		int r;
		int e;
		write_limit(lim);
		steady  = no_idle;
		stop_at = symbols_sent + quota;
		e       = effective_limit();
		while (symbols_sent < stop_at) begin
			r = $urandom_range(0, 99);
			if (r < 85) begin
				if ($urandom_range(0, 9) == 0)
					build_nested(e + $urandom_range(0, 1), 2 * e + 4, 1'b1);
				else
					build_nested($urandom_range(1, e < 6 ? e : 6), $urandom_range(1, 20), 1'b0);
				if (r >= 70)
					corrupt_text();
			end else begin
				build_noise();
			end
			send_text();
		end
		steady = 1'b0;
	endtask

	always @(posedge clk) begin : result_check
		verdict_t want;
		if (m_axis_tvalid && m_axis_tready) begin
			if (pending_verdicts.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("unexpected result tdata=%h with nothing pending", m_axis_tdata);
			end else begin
				want = pending_verdicts.pop_front();
				if (m_axis_tdata[0] !== want.balanced || m_axis_tdata[3:1] !== want.reason
						|| m_axis_tdata[7:4] !== 4'd0) begin
					mismatches++;
					if (mismatches <= 10)
						$display("mismatch at %0t: balanced exp %0d got %0d, reason exp %0d got %0d, pad %h",
							$realtime, want.balanced, m_axis_tdata[0], want.reason,
							m_axis_tdata[3:1], m_axis_tdata[7:4]);
				end
			end
		end
		m_axis_tready <= steady || ($urandom_range(0, 99) >= 13);
	end

	// watchdog on cycles without any transfer
	always @(posedge clk) begin
		if (arst_n) begin
			if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)
					|| (cfg_valid && cfg_ready))
				idle_cycles <= 0;
			else
				idle_cycles <= idle_cycles + 1;
			if (idle_cycles >= IDLE_LIMIT) begin
				$display("timeout: no transfer for %0d cycles", IDLE_LIMIT);
				$display("Some tests failed");
				$finish;
			end
		end
	end

	initial begin
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_directed();
		test_limit_bounds();
		test_limit_lowered();
		test_random_phase(7'd64, 130, 1'b0);
		test_random_phase(7'd3, 120, 1'b0);
		test_random_phase(7'd127, 110, 1'b1);
		test_random_phase(7'd0, 60, 1'b0);
		test_random_phase(7'($urandom_range(1, 127)), 120, 1'b0);
		test_random_phase(7'd64, 80, 1'b0);
		drain_verdicts();
		$display("sent %0d characters over %0d strings, limits from 0 to 127",
			symbols_sent, reason_tally.sum());
		$display("verdicts: balanced %0d, closer on empty %0d, wrong closer %0d, overflow %0d, left open %0d",
			reason_tally[ERR_NONE], reason_tally[ERR_EMPTY], reason_tally[ERR_WRONG],
			reason_tally[ERR_OVERFLOW], reason_tally[ERR_OPEN]);
		if (mismatches == 0 && pending_verdicts.size() == 0)
			$display("All tests passed");
		else
			$display("Some tests failed");
		$finish;
	end

endmodule
